// ===== rtl/core/plc_pkg.sv =====
// Package for the posting list cursor: command codes, datapath operations
// and the status bundle passed from the datapath to the controller.
// Depends on nothing.
package plc_pkg;

	// Command codes carried by an input item.
	typedef enum logic [2:0] {
		CMD_CLEAR   = 3'd0,
		CMD_APPEND  = 3'd1,
		CMD_REWIND  = 3'd2,
		CMD_NEXT    = 3'd3,
		CMD_CURRENT = 3'd4,
		CMD_ADVANCE = 3'd5
	} cmd_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_READ
	} ctrl_state_t;

	// Operations the controller orders from the datapath each cycle.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_APPEND,
		OP_REWIND,
		OP_PARK,
		OP_HOLD,
		OP_STEP_READ,
		OP_CUR_READ,
		OP_SEARCH_START,
		OP_SEARCH_STEP,
		OP_SEARCH_FETCH,
		OP_DELIVER
	} dp_op_t;

	// Status flags from the datapath.
	typedef struct packed {
		logic next_end;
		logic cur_end;
		logic count_zero;
		logic search_done;
		logic pos_end;
	} dp_status_t;

endpackage

// ===== rtl/core/plc_ram.sv =====
// Generic single write port, single read port RAM with a registered read.
// Depends on nothing.
module plc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/plc_ctrl.sv =====
// Controller state machine of the posting list cursor.
// Depends on plc_pkg; drives plc_datapath through dp_op_t.
module plc_ctrl import plc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] command,
	input  dp_status_t dp_status,
	output dp_op_t     dp_op,
	output logic       busy
);

	ctrl_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath operation.
	always_comb begin
		state_d = state_q;
		dp_op   = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (cmd_t'(command))
						CMD_CLEAR:  dp_op = OP_CLEAR;
						CMD_APPEND: dp_op = OP_APPEND;
						CMD_REWIND: dp_op = OP_REWIND;
						CMD_NEXT: begin
							if (dp_status.next_end) begin
								dp_op = OP_PARK;
							end else begin
								dp_op   = OP_STEP_READ;
								state_d = ST_READ;
							end
						end
						CMD_CURRENT: begin
							if (dp_status.cur_end) begin
								dp_op = OP_PARK;
							end else begin
								dp_op   = OP_CUR_READ;
								state_d = ST_READ;
							end
						end
						CMD_ADVANCE: begin
							if (dp_status.count_zero) begin
								dp_op = OP_PARK;
							end else begin
								dp_op   = OP_SEARCH_START;
								state_d = ST_SEARCH;
							end
						end
						default: dp_op = OP_HOLD;
					endcase
				end
			end
			ST_SEARCH: begin
				if (!dp_status.search_done) begin
					dp_op = OP_SEARCH_STEP;
				end else if (dp_status.pos_end) begin
					dp_op   = OP_PARK;
					state_d = ST_IDLE;
				end else begin
					dp_op   = OP_SEARCH_FETCH;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				dp_op   = OP_DELIVER;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== rtl/core/plc_datapath.sv =====
// Datapath of the posting list cursor: count, cursor, search window and
// result registers, plus the address and write controls of the id RAM.
// Depends on plc_pkg.
module plc_datapath import plc_pkg::*; #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dp_op_t                         dp_op,
	input  logic [31:0]                    doc_value,
	output dp_status_t                     dp_status,
	output logic                           ram_we,
	output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr,
	output logic [31:0]                    ram_wdata,
	output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr,
	input  logic [31:0]                    ram_rdata,
	output logic                           done,
	output logic [31:0]                    doc_result,
	output logic [10:0]                    cursor_position,
	output logic                           at_end,
	output logic                           status
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	logic [CW-1:0] count_q, cursor_q, first_q, len_q;
	logic [31:0]   target_q;
	logic [CW-1:0] count_d, cursor_d;
	logic [CW-1:0] probe, first_n, len_n, raddr_full;
	logic [CW:0]   cursor_plus2;
	logic          below, full, report;
	logic [CW+10:0] cursor_ext;

	// Search step: compare the probed id and narrow the window.
	assign probe   = first_q + (len_q >> 1);
	assign below   = (ram_rdata < target_q);
	assign first_n = below ? CW'(probe + 1'b1) : first_q;
	assign len_n   = below ? CW'(len_q - (len_q >> 1) - 1'b1) : (len_q >> 1);

	// Status for the controller.
	assign full         = (count_q == DEPTH_C);
	assign cursor_plus2 = {1'b0, cursor_q} + (CW+1)'(2);
	assign dp_status.next_end    = (cursor_plus2 > {1'b0, count_q});
	assign dp_status.cur_end     = (cursor_q >= count_q);
	assign dp_status.count_zero  = (count_q == '0);
	assign dp_status.search_done = (len_n == '0);
	assign dp_status.pos_end     = (first_n >= count_q);

	// RAM controls.
	assign ram_we    = (dp_op == OP_APPEND) && !full;
	assign ram_waddr = count_q[AW-1:0];
	assign ram_wdata = doc_value;

	always_comb begin
		case (dp_op)
			OP_STEP_READ:    raddr_full = CW'(cursor_q + 1'b1);
			OP_SEARCH_START: raddr_full = count_q >> 1;
			OP_SEARCH_STEP:  raddr_full = CW'(first_n + (len_n >> 1));
			OP_SEARCH_FETCH: raddr_full = first_n;
			default:         raddr_full = cursor_q;
		endcase
	end
	assign ram_raddr = raddr_full[AW-1:0];

	// Next count and cursor for each operation.
	always_comb begin
		count_d  = count_q;
		cursor_d = cursor_q;
		case (dp_op)
			OP_CLEAR: begin
				count_d  = '0;
				cursor_d = '0;
			end
			OP_APPEND: begin
				if (!full) begin
					count_d = CW'(count_q + 1'b1);
				end
			end
			OP_REWIND:       cursor_d = '0;
			OP_PARK:         cursor_d = count_q;
			OP_STEP_READ:    cursor_d = CW'(cursor_q + 1'b1);
			OP_SEARCH_FETCH: cursor_d = first_n;
			default: ;
		endcase
	end

	assign report = (dp_op == OP_CLEAR) || (dp_op == OP_APPEND) ||
	                (dp_op == OP_REWIND) || (dp_op == OP_PARK) ||
	                (dp_op == OP_HOLD) || (dp_op == OP_DELIVER);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cursor_q <= '0;
			done     <= 1'b0;
		end else begin
			count_q  <= count_d;
			cursor_q <= cursor_d;
			done     <= report;
		end
	end

	assign cursor_ext = {11'b0, cursor_d};

	// Search window and result registers.
	always_ff @(posedge clk) begin
		case (dp_op)
			OP_SEARCH_START: begin
				first_q  <= '0;
				len_q    <= count_q;
				target_q <= doc_value;
			end
			OP_SEARCH_STEP: begin
				first_q <= first_n;
				len_q   <= len_n;
			end
			default: ;
		endcase
		if (report) begin
			doc_result      <= (dp_op == OP_DELIVER) ? ram_rdata : 32'd0;
			cursor_position <= cursor_ext[10:0];
			at_end          <= (cursor_d == count_d);
			status          <= (dp_op == OP_APPEND) && full;
		end
	end

endmodule

// ===== rtl/core/posting_list_cursor.sv =====
// Top level of the posting list cursor: controller, datapath and id RAM.
// Depends on plc_pkg, plc_ctrl, plc_datapath and plc_ram.
//
// Usage: drive command and doc_value with start high; the item is taken at
// the rising edge where start is high and busy is low. Each item gives one
// result on doc_result, cursor_position, at_end and status, shown for one
// cycle with done high. The receiver cannot stall, so results must be taken
// as they appear.
// Clear, append, rewind, unused codes and any query that ends at once (empty
// table, or no entry for the cursor to read) report in the cycle after
// acceptance with busy staying low, so such items may follow every cycle.
// Next and current read the id RAM once; busy is high in the read state,
// where the registered RAM data is taken into the result registers.
// Advance runs the lower-bound search, one RAM read and compare per cycle:
// at most floor(log2(count))+1 probes, then, if the search ends inside the
// table, one read of the found entry.
// Reset clears the count and the cursor; the id RAM needs no clearing, as
// only entries written since the last clear are ever read.
module posting_list_cursor import plc_pkg::*; #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  command,
	input  logic [31:0] doc_value,
	output logic        done,
	output logic [31:0] doc_result,
	output logic [10:0] cursor_position,
	output logic        at_end,
	output logic        status
);

	localparam int AW = $clog2(TABLE_DEPTH);

	dp_op_t     dp_op;
	dp_status_t dp_status;
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_wdata, ram_rdata;

	// Command sequencing.
	plc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.command   (command),
		.dp_status (dp_status),
		.dp_op     (dp_op),
		.busy      (busy)
	);

	// Count, cursor, search window and results.
	plc_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.dp_op           (dp_op),
		.doc_value       (doc_value),
		.dp_status       (dp_status),
		.ram_we          (ram_we),
		.ram_waddr       (ram_waddr),
		.ram_wdata       (ram_wdata),
		.ram_raddr       (ram_raddr),
		.ram_rdata       (ram_rdata),
		.done            (done),
		.doc_result      (doc_result),
		.cursor_position (cursor_position),
		.at_end          (at_end),
		.status          (status)
	);

	// Document id store.
	plc_ram #(
		.WIDTH (32),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

// ===== verif/posting_list_cursor_test.sv =====
// Self-checking testbench for the posting list cursor: directed items, then
// sorted, unsorted and noisy command sequences, all checked by a scoreboard.
// Depends on plc_pkg and the posting_list_cursor top level.
module posting_list_cursor_test;
	import plc_pkg::*;

	localparam int DEPTH        = 1024;
	localparam int RANDOM_ITEMS = 1500;
	localparam int DRAIN_CYCLES = 24;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int SHOWN_ERRORS = 10;

	// Command codes that the block ignores.
	localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
	localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

	typedef struct {
		logic [31:0] doc;
		logic [10:0] pos;
		logic        at_end;
		logic        status;
	} cursor_result_t;

	// Tracks the id table and cursor, and holds the results still to come.
	class cursor_scoreboard;
		logic [31:0]    id_table [DEPTH];
		int unsigned    entry_count;
		int unsigned    cursor;
		cursor_result_t expected_q [$];
		int unsigned    errors;

		function new();
			entry_count = 0;
			cursor = 0;
			errors = 0;
		endfunction

		// Lower-bound search: first index whose id is not below the target.
		function int unsigned first_at_or_above(logic [31:0] target);
			int unsigned first;
			int unsigned len;
			int unsigned half;
			first = 0;
			len = entry_count;
			while (len > 0) begin
				half = len / 2;
				if (first + half < DEPTH && id_table[first + half] < target) begin
					first = first + half + 1;
					len = len - half - 1;
				end else begin
					len = half;
				end
			end
			return first;
		endfunction

		// Applies an accepted item to the state and queues its result.
		function void note_item(logic [2:0] cmd, logic [31:0] value);
			cursor_result_t r;
			int unsigned    pos;
			r.doc = '0;
			r.status = 1'b0;
			case (cmd)
			CMD_CLEAR: begin
				entry_count = 0;
				cursor = 0;
			end
			CMD_APPEND: begin
				if (entry_count < DEPTH) begin
					id_table[entry_count] = value;
					entry_count++;
				end else begin
					r.status = 1'b1;
				end
			end
			CMD_REWIND: cursor = 0;
			CMD_NEXT: begin
				if (entry_count != 0) begin
					if (cursor + 2 > entry_count) begin
						cursor = entry_count;
					end else begin
						cursor++;
						r.doc = id_table[cursor];
					end
				end
			end
			CMD_CURRENT: begin
				if (entry_count != 0) begin
					if (cursor + 1 > entry_count)
						cursor = entry_count;
					else
						r.doc = id_table[cursor];
				end
			end
			CMD_ADVANCE: begin
				pos = first_at_or_above(value);
				if (pos >= entry_count) begin
					cursor = entry_count;
				end else begin
					cursor = pos;
					r.doc = id_table[pos];
				end
			end
			default: ;
			endcase
			r.pos = cursor[10:0];
			r.at_end = (cursor == entry_count);
			expected_q.insert(expected_q.size(), r);
		endfunction

		// Compares one result with the oldest expectation.
		function void check_result(logic [31:0] doc, logic [10:0] pos, logic at_end,
			logic status);
			cursor_result_t e;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= SHOWN_ERRORS)
					$display("%0t: result with nothing expected: doc %h pos %0d end %b st %b",
						$time, doc, pos, at_end, status);
				return;
			end
			e = expected_q.pop_front();
			if (doc !== e.doc || pos !== e.pos || at_end !== e.at_end || status !== e.status)
			begin
				errors++;
				if (errors <= SHOWN_ERRORS)
					$display("%0t: expected %h/%0d/%b/%b, got %h/%0d/%b/%b",
						$time, e.doc, e.pos, e.at_end, e.status, doc, pos, at_end, status);
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [2:0]  command = CMD_CLEAR;
	logic [31:0] doc_value = '0;
	logic        busy;
	logic        done;
	logic [31:0] doc_result;
	logic [10:0] cursor_position;
	logic        at_end;
	logic        status;

	cursor_scoreboard sb;
	int unsigned      burst_left = 0;
	int unsigned      items_sent = 0;
	logic [31:0]      seq_ids [$];

	posting_list_cursor #(.TABLE_DEPTH(DEPTH)) i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.doc_value       (doc_value),
		.done            (done),
		.doc_result      (doc_result),
		.cursor_position (cursor_position),
		.at_end          (at_end),
		.status          (status)
	);

	// Clock with a period of 12 time units.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Every result is checked at the edge that ends its strobe cycle.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(doc_result, cursor_position, at_end, status);
	end

	// Watchdog on the whole run.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("[posting_list_cursor] ERROR");
		$finish;
	end

	// Presents one item at a falling edge and holds it until it is taken.
	// Items go out in bursts of random length with random gaps in between.
	task automatic send_item(input logic [2:0] cmd, input logic [31:0] value);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				start = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 16);
		end
		burst_left--;
		start = 1'b1;
		command = cmd;
		doc_value = value;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_item(cmd, value);
		if (cmd <= CMD_ADVANCE)
			items_sent++;
		@(negedge clk);
	endtask

	// Advance target: mostly a stored id or a neighbour of one.
	function automatic logic [31:0] pick_target();
		int unsigned r;
		logic [31:0] base;
		r = $urandom_range(0, 9);
		if (seq_ids.size() == 0 || r >= 8)
			return $urandom();
		base = seq_ids[$urandom_range(0, seq_ids.size() - 1)];
		case (r)
		0, 1, 2: return base;
		3, 4: return base + 32'd1;
		5, 6: return base - 32'd1;
		default: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
		endcase
	endfunction

	// One random query: next, current, rewind or advance.
	task automatic send_query();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 30)
			send_item(CMD_NEXT, $urandom());
		else if (r < 45)
			send_item(CMD_CURRENT, $urandom());
		else if (r < 55)
			send_item(CMD_REWIND, $urandom());
		else
			send_item(CMD_ADVANCE, pick_target());
	endtask

	// Well-formed list: optional clear, ascending nonzero ids, then queries.
	task automatic sorted_phase(input int unsigned n_ids, input int unsigned n_queries,
		input bit fresh);
		logic [31:0] id;
		logic [31:0] step_max;
		if (fresh) begin
			send_item(CMD_CLEAR, $urandom());
			seq_ids.delete();
		end
		id = (seq_ids.size() != 0) ? seq_ids[$] : 32'h0;
		step_max = (32'hFFFF_FFFF - id) / (n_ids + 1);
		if (step_max == 0)
			step_max = 1;
		repeat (n_ids) begin
			id = id + $urandom_range(1, step_max);
			send_item(CMD_APPEND, id);
			seq_ids.insert(seq_ids.size(), id);
		end
		repeat (n_queries)
			send_query();
	endtask

	// Broken list: unsorted ids, zeros among them, then queries.
	task automatic unsorted_phase(input int unsigned n_ids, input int unsigned n_queries);
		logic [31:0] id;
		send_item(CMD_CLEAR, $urandom());
		seq_ids.delete();
		repeat (n_ids) begin
			id = ($urandom_range(0, 5) == 0) ? 32'h0 : $urandom();
			send_item(CMD_APPEND, id);
			seq_ids.insert(seq_ids.size(), id);
		end
		repeat (n_queries)
			send_query();
	endtask

	// Noise: any command code with any value.
	task automatic noise_phase(input int unsigned n_items);
		repeat (n_items)
			send_item(3'($urandom_range(0, 7)), $urandom());
	endtask

	initial begin
		int unsigned kind;
		sb = new();

		// Reset held, then released at a falling edge.
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed items: empty table, ends of the list, extremes of the ids,
		// unsorted and zero ids, and the ignored codes.
		send_item(CMD_CURRENT, 32'h0);
		send_item(CMD_NEXT, 32'hFFFF_FFFF);
		send_item(CMD_ADVANCE, 32'h0);
		send_item(CMD_APPEND, 32'h1);
		send_item(CMD_APPEND, 32'd20);
		send_item(CMD_APPEND, 32'h8000_0000);
		send_item(CMD_APPEND, 32'hFFFF_FFFF);
		send_item(CMD_CURRENT, 32'h0);
		repeat (4)
			send_item(CMD_NEXT, 32'h0);
		send_item(CMD_CURRENT, 32'h0);
		send_item(CMD_REWIND, 32'hFFFF_FFFF);
		send_item(CMD_ADVANCE, 32'h0);
		send_item(CMD_ADVANCE, 32'd21);
		send_item(CMD_ADVANCE, 32'hFFFF_FFFF);
		send_item(CMD_APPEND, 32'd5);
		send_item(CMD_APPEND, 32'h0);
		send_item(CMD_ADVANCE, 32'd6);
		send_item(CMD_ADVANCE, 32'hFFFF_FFFF);
		send_item(CMD_UNUSED_LO, 32'h5555_5555);
		send_item(CMD_UNUSED_HI, 32'hAAAA_AAAA);
		send_item(CMD_CLEAR, 32'hFFFF_FFFF);
		send_item(CMD_ADVANCE, 32'h1);

		// Random part, opening with a full table and appends that are dropped.
		items_sent = 0;
		sorted_phase(DEPTH + 3, 40, 1'b1);
		while (items_sent < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			if (kind < 7)
				sorted_phase($urandom_range(1, ($urandom_range(0, 3) == 0) ? 120 : 24),
					$urandom_range(4, 30), $urandom_range(0, 4) != 0);
			else if (kind < 9)
				unsorted_phase($urandom_range(1, 24), $urandom_range(4, 24));
			else
				noise_phase($urandom_range(5, 30));
		end
		start = 1'b0;

		// Wait for the last results, then a little longer for strays.
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0)
			$display("[posting_list_cursor] OK");
		else
			$display("[posting_list_cursor] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/plc_pkg.sv
rtl/core/plc_ram.sv
rtl/core/plc_ctrl.sv
rtl/core/plc_datapath.sv
rtl/core/posting_list_cursor.sv
verif/posting_list_cursor_test.sv
